FILE: rtl/hgs_pkg.sv
`timescale 1ns / 1ps
package hgs_pkg;

	// default parameter values
	localparam int GAIN_WIDTH_DEF     = 24;
	localparam int TEMP_FRAC_BITS_DEF = 4;

	// field widths
	localparam int AVG_W   = 13;
	localparam int SPREAD_W = 12;
	localparam int TARGET_W = 9;
	localparam int STAGE_W  = 3;
	localparam int GAINF_W  = 24;
	localparam int IN_W     = 40;
	localparam int OUT_W    = 72;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_KP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_KI    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_KD    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STAGE_TUNE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LEARN      = 3'd4;

	localparam logic [CFG_DATA_W-1:0] BASE_KP_RST = 24'd131072;
	localparam logic [CFG_DATA_W-1:0] BASE_KI_RST = 24'd3277;
	localparam logic [CFG_DATA_W-1:0] BASE_KD_RST = 24'd78643;

	// q1.16 scale factors
	localparam int FACT_W = 17;
	localparam logic [FACT_W-1:0] ONE_Q16   = 17'd65536;
	localparam logic [FACT_W-1:0] TWO_Q16_M = 17'd131071;
	localparam logic [FACT_W-1:0] FLOOR_Q16 = 17'd19661;
	localparam logic [FACT_W-1:0] BOOST_Q16 = 17'd72090;
	localparam logic [FACT_W-1:0] ROUND_Q16 = 17'd32768;

	// division by five through a reciprocal: floor(x * RECIP_M >> RECIP_SH) for x < 2^25
	localparam int RECIP_X_W = 25;
	localparam int RECIP_M_W = 26;
	localparam int RECIP_SH  = 28;
	localparam logic [RECIP_M_W-1:0] RECIP_M = 26'd53687092;
	// span of 40 C is 5 * 2^3 C, so d * 2^16 / span = (d << (13 - frac)) / 5
	localparam int SPAN_SHIFT_BASE = 13;

	// profile stages
	localparam logic [STAGE_W-1:0] STG_PREHEAT  = 3'd0;
	localparam logic [STAGE_W-1:0] STG_SOAK     = 3'd1;
	localparam logic [STAGE_W-1:0] STG_RAMP     = 3'd2;
	localparam logic [STAGE_W-1:0] STG_PEAK     = 3'd3;
	localparam logic [STAGE_W-1:0] STG_COOLDOWN = 3'd4;
	localparam logic [STAGE_W-1:0] STG_COUNT    = 3'd5;

	// shared multiplier operations
	typedef logic [2:0] op_t;
	localparam op_t OP_STAGE_KP = 3'd0;
	localparam op_t OP_STAGE_KI = 3'd1;
	localparam op_t OP_STAGE_KD = 3'd2;
	localparam op_t OP_DAMP_KP  = 3'd3;
	localparam op_t OP_DAMP_KD  = 3'd4;
	localparam op_t OP_BOOST_KI = 3'd5;

	typedef struct packed {
		logic [FACT_W-1:0] kd;
		logic [FACT_W-1:0] ki;
		logic [FACT_W-1:0] kp;
	} scale3_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic mul_go;
		op_t  op;
		logic out_load;
	} hgs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic stage_ok;
		logic damp_on;
		logic boost_on;
	} hgs_sts_t;

	// per-stage gain scaling
	function automatic scale3_t stage_scale(input logic [STAGE_W-1:0] stg);
		scale3_t s;
		case (stg)
			STG_PREHEAT:  s = '{kp: 17'd78643, ki: 17'd32768, kd: 17'd52429};
			STG_SOAK:     s = '{kp: 17'd52429, ki: 17'd98304, kd: 17'd32768};
			STG_RAMP:     s = '{kp: 17'd65536, ki: 17'd65536, kd: 17'd85197};
			STG_PEAK:     s = '{kp: 17'd39322, ki: 17'd19661, kd: 17'd117965};
			STG_COOLDOWN: s = '{kp: 17'd6554, ki: 17'd0, kd: 17'd6554};
			default:      s = '{kp: ONE_Q16, ki: ONE_Q16, kd: ONE_Q16};
		endcase
		return s;
	endfunction

endpackage

FILE: rtl/heating_gain_scheduler.sv
`timescale 1ns / 1ps
// m_tvalid rises after the controller steps the item through load, six gain
// products on the shared multiplier, drain and output; the input stays closed
// until the result is loaded, and output waits while the output register is unread
// a finished result waits in the output register while the next item runs
// reset: state machine idle, config registers to defaults, spread history 0
module heating_gain_scheduler
	import hgs_pkg::*;
#(
	parameter int GAIN_WIDTH     = GAIN_WIDTH_DEF,
	parameter int TEMP_FRAC_BITS = TEMP_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_W-1:0]       s_tdata,  // avg_temp, spatial_delta, target_temp, stage
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_W-1:0]      m_tdata   // kp, ki, kd
);

	hgs_cmd_t cmd;
	hgs_sts_t sts;

	hgs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hgs_datapath #(
		.GAIN_WIDTH     (GAIN_WIDTH),
		.TEMP_FRAC_BITS (TEMP_FRAC_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.m_tdata   (m_tdata)
	);

	// output register is only overwritten once its transaction is done
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("output overwritten before its transaction");

	// an accepted item keeps the input closed until its result is loaded
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input reopened right after a transaction");

	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> ##8 !s_tready)
		else $error("input reopened before the gain sequence finished");

	// the multiplier never runs while an item is being loaded
	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.mul_go))
		else $error("load and multiply in the same cycle");

endmodule

FILE: rtl/hgs_datapath.sv
`timescale 1ns / 1ps
module hgs_datapath
	import hgs_pkg::*;
#(
	parameter int GAIN_WIDTH     = GAIN_WIDTH_DEF,
	parameter int TEMP_FRAC_BITS = TEMP_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [IN_W-1:0]       s_tdata,
	input  hgs_cmd_t              cmd,
	output hgs_sts_t              sts,
	output logic [OUT_W-1:0]      m_tdata
);

	localparam int GW  = GAIN_WIDTH;
	localparam int PW  = GW + FACT_W;
	localparam int QW  = RECIP_X_W + RECIP_M_W - RECIP_SH;
	localparam int DSH = SPAN_SHIFT_BASE - TEMP_FRAC_BITS;
	localparam int MAGW = (TARGET_W + TEMP_FRAC_BITS > AVG_W) ?
		TARGET_W + TEMP_FRAC_BITS : AVG_W;
	localparam int EW  = MAGW + 2;
	localparam logic [SPREAD_W:0] LO_THR  = (SPREAD_W + 1)'(20 << TEMP_FRAC_BITS);
	localparam logic [EW-1:0]     ERR_LO  = EW'(5 << TEMP_FRAC_BITS);
	localparam logic [EW-1:0]     ERR_HI  = EW'(20 << TEMP_FRAC_BITS);

	// configuration registers
	logic [GW-1:0] base_kp_q, base_ki_q, base_kd_q;
	logic          stage_tune_q, learn_q;
	logic [SPREAD_W-1:0] prev_spread_q;

	// item registers
	logic [GW-1:0]      kp_q, ki_q, kd_q;
	logic [STAGE_W-1:0] stage_q;
	logic               stage_ok_q, damp_on_q, boost_q;
	logic [RECIP_X_W+RECIP_M_W-1:0] q_prod_s1;
	logic [FACT_W-1:0]  factor_q;
	logic [PW-1:0]      prod_s1;
	op_t                op_s1;
	logic               we_s1;
	logic [OUT_W-1:0]   out_q;

	// input fields
	logic [AVG_W-1:0]    avg;
	logic [SPREAD_W-1:0] spread;
	logic [TARGET_W-1:0] target;
	logic [STAGE_W-1:0]  stage;
	assign avg    = s_tdata[AVG_W-1:0];
	assign spread = s_tdata[AVG_W +: SPREAD_W];
	assign target = s_tdata[AVG_W+SPREAD_W +: TARGET_W];
	assign stage  = s_tdata[AVG_W+SPREAD_W+TARGET_W +: STAGE_W];

	// spread excess and its scaled numerator for the damping quotient
	logic                 damp_on;
	logic [SPREAD_W-1:0]  d_excess;
	logic [RECIP_X_W-1:0] x_num;
	assign damp_on  = {1'b0, spread} > LO_THR;
	assign d_excess = SPREAD_W'({1'b0, spread} - LO_THR);
	assign x_num    = RECIP_X_W'(d_excess) << DSH;

	// integral boost rule, compared against the stored spread
	logic signed [EW-1:0] err, derr;
	logic [EW-1:0]        aerr, aderr;
	logic                 boost_on;
	always_comb begin
		err   = $signed(EW'(target) << TEMP_FRAC_BITS) - $signed(EW'(avg));
		derr  = err - $signed(EW'(prev_spread_q));
		aerr  = err[EW-1] ? EW'(-err) : EW'(err);
		aderr = derr[EW-1] ? EW'(-derr) : EW'(derr);
		boost_on = learn_q && (aderr > ERR_LO) && (aerr < ERR_HI);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_kp_q    <= GW'(BASE_KP_RST);
			base_ki_q    <= GW'(BASE_KI_RST);
			base_kd_q    <= GW'(BASE_KD_RST);
			stage_tune_q <= 1'b0;
			learn_q      <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE_KP:    base_kp_q    <= GW'(cfg_data);
				REG_BASE_KI:    base_ki_q    <= GW'(cfg_data);
				REG_BASE_KD:    base_kd_q    <= GW'(cfg_data);
				REG_STAGE_TUNE: stage_tune_q <= cfg_data[0];
				REG_LEARN:      learn_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// per-item flags and spread history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_spread_q <= '0;
			stage_ok_q    <= 1'b0;
			damp_on_q     <= 1'b0;
			boost_q       <= 1'b0;
			we_s1         <= 1'b0;
		end else begin
			if (cmd.load) begin
				stage_ok_q <= stage_tune_q && (stage < STG_COUNT);
				damp_on_q  <= damp_on;
				boost_q    <= boost_on;
				if (learn_q)
					prev_spread_q <= spread;
			end
			we_s1 <= cmd.mul_go;
		end
	end

	assign sts = '{stage_ok: stage_ok_q, damp_on: damp_on_q, boost_on: boost_q};

	// damping factor from the registered quotient, floored at 0.3
	logic [QW-1:0]     quot;
	logic [FACT_W-1:0] factor_d;
	assign quot = q_prod_s1[RECIP_SH +: QW];
	always_comb begin
		if (quot >= QW'(ONE_Q16 - FLOOR_Q16))
			factor_d = FLOOR_Q16;
		else
			factor_d = ONE_Q16 - FACT_W'(quot);
	end

	// shared multiplier operand select
	scale3_t           stg_f;
	logic [GW-1:0]     opa;
	logic [FACT_W-1:0] opb;
	always_comb begin
		stg_f = stage_scale(stage_q);
		unique case (cmd.op)
			OP_STAGE_KP: begin opa = kp_q; opb = stg_f.kp; end
			OP_STAGE_KI: begin opa = ki_q; opb = stg_f.ki; end
			OP_STAGE_KD: begin opa = kd_q; opb = stg_f.kd; end
			OP_DAMP_KP:  begin opa = kp_q; opb = factor_q; end
			OP_DAMP_KD:  begin opa = kd_q; opb = TWO_Q16_M - factor_q + FACT_W'(1); end
			OP_BOOST_KI: begin opa = ki_q; opb = BOOST_Q16; end
			default:     begin opa = '0;   opb = '0; end
		endcase
	end

	// round half up and saturate
	logic [PW:0]     rnd;
	logic [GW+1:0]   shr;
	logic [GW-1:0]   sat;
	always_comb begin
		rnd = (PW + 1)'(prod_s1) + (PW + 1)'(ROUND_Q16);
		shr = rnd[PW:FACT_W-1];
		sat = (|shr[GW+1:GW]) ? '1 : shr[GW-1:0];
	end

	// gain registers, multiplier stage and writeback
	always_ff @(posedge clk) begin
		q_prod_s1 <= (cmd.load) ? x_num * RECIP_M : q_prod_s1;
		factor_q  <= factor_d;
		if (cmd.mul_go) begin
			prod_s1 <= opa * opb;
			op_s1   <= cmd.op;
		end
		if (cmd.load) begin
			kp_q    <= base_kp_q;
			ki_q    <= base_ki_q;
			kd_q    <= base_kd_q;
			stage_q <= stage;
		end else if (we_s1) begin
			unique case (op_s1)
				OP_STAGE_KP, OP_DAMP_KP:  kp_q <= sat;
				OP_STAGE_KI, OP_BOOST_KI: ki_q <= sat;
				OP_STAGE_KD, OP_DAMP_KD:  kd_q <= sat;
				default: ;
			endcase
		end
		if (cmd.out_load)
			out_q <= {GAINF_W'(kd_q), GAINF_W'(ki_q), GAINF_W'(kp_q)};
	end

	assign m_tdata = out_q;

endmodule

FILE: rtl/hgs_ctrl.sv
`timescale 1ns / 1ps
module hgs_ctrl
	import hgs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	input  hgs_sts_t sts,
	output hgs_cmd_t cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SKP   = 4'd1;
	localparam logic [3:0] ST_SKI   = 4'd2;
	localparam logic [3:0] ST_SKD   = 4'd3;
	localparam logic [3:0] ST_DKP   = 4'd4;
	localparam logic [3:0] ST_DKD   = 4'd5;
	localparam logic [3:0] ST_BOOST = 4'd6;
	localparam logic [3:0] ST_DRAIN = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;

	// command decode and next state
	always_comb begin
		state_d      = state_q;
		cmd.load     = 1'b0;
		cmd.mul_go   = 1'b0;
		cmd.op       = OP_STAGE_KP;
		cmd.out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = s_tvalid;
				if (s_tvalid)
					state_d = ST_SKP;
			end
			ST_SKP: begin
				cmd.op     = OP_STAGE_KP;
				cmd.mul_go = sts.stage_ok;
				state_d    = ST_SKI;
			end
			ST_SKI: begin
				cmd.op     = OP_STAGE_KI;
				cmd.mul_go = sts.stage_ok;
				state_d    = ST_SKD;
			end
			ST_SKD: begin
				cmd.op     = OP_STAGE_KD;
				cmd.mul_go = sts.stage_ok;
				state_d    = ST_DKP;
			end
			ST_DKP: begin
				cmd.op     = OP_DAMP_KP;
				cmd.mul_go = sts.damp_on;
				state_d    = ST_DKD;
			end
			ST_DKD: begin
				cmd.op     = OP_DAMP_KD;
				cmd.mul_go = sts.damp_on;
				state_d    = ST_BOOST;
			end
			ST_BOOST: begin
				cmd.op     = OP_BOOST_KI;
				cmd.mul_go = sts.boost_on;
				state_d    = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_OUT;
			ST_OUT: begin
				// wait for the output register to free up
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import hgs_pkg::*;

	// spread knee, damping span and learning window, in 1/16 C
	localparam int TEMP_SCALE  = 16;
	localparam int SPREAD_KNEE = 20 * TEMP_SCALE;
	localparam int DAMP_SPAN   = 40 * TEMP_SCALE;
	localparam int BOOST_GAP   = 5 * TEMP_SCALE;
	localparam int ERR_WINDOW  = 20 * TEMP_SCALE;

	// q2.16 factors used by the gain predictor
	localparam logic [17:0] UNITY      = 18'd65536;
	localparam logic [17:0] DAMP_FLOOR = 18'd19661;
	localparam logic [17:0] KI_BOOST   = 18'd72090;
	localparam logic [63:0] HALF_LSB   = 64'd32768;
	localparam logic [23:0] GAIN_SAT   = 24'hFFFFFF;

	// register indexes past the end of the register map
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_C = 3'd7;

	// stage codes with no scaling row
	localparam logic [STAGE_W-1:0] STG_OTHER = STG_COUNT;
	localparam logic [STAGE_W-1:0] STG_CODE6 = 3'd6;
	localparam logic [STAGE_W-1:0] STG_CODE7 = 3'd7;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SEGMENTS      = 6;
	localparam int SEG_READINGS  = 142;
	localparam int SETTLE_CYCLES = 20;

	typedef struct packed {
		logic [STAGE_W-1:0]  stage;
		logic [TARGET_W-1:0] target;
		logic [SPREAD_W-1:0] spread;
		logic [AVG_W-1:0]    avg;
	} reading_t;

	typedef struct packed {
		logic [GAINF_W-1:0] kd;
		logic [GAINF_W-1:0] ki;
		logic [GAINF_W-1:0] kp;
	} gains_t;

	typedef struct packed {
		logic [17:0] kp;
		logic [17:0] ki;
		logic [17:0] kd;
	} factors_t;

	// one row of the directed plan: a register write or a reading
	typedef struct packed {
		logic                  is_reg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		reading_t              rd;
		logic                  fixed;
		gains_t                want;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata = '0;  // avg_temp, spatial_delta, target_temp, stage
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_W-1:0]      m_tdata;  // kp, ki, kd

	// predictor copy of the registers and the spread history
	logic [23:0]         gain_kp;
	logic [23:0]         gain_ki;
	logic [23:0]         gain_kd;
	logic                stage_tune_on;
	logic                learn_on;
	logic [SPREAD_W-1:0] last_spread;

	gains_t pending_gains[$];
	int     send_idle_pct = 17;
	int     recv_idle_pct = 66;
	int     cycle_count = 0;
	int     mismatches = 0;
	int     readings_sent = 0;
	int     gains_checked = 0;
	int     reg_writes = 0;
	int     damped_count = 0;
	int     boosted_count = 0;

	heating_gain_scheduler u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [23:0] got,
		input logic [23:0] want);
		$display("mismatch %s: got 0x%06h expected 0x%06h (cycle %0d)", what, got, want,
			cycle_count);
		mismatches++;
	endtask

	// round half up, then saturate
	function automatic logic [23:0] scale_q16(input logic [23:0] gain, input logic [17:0] f);
		logic [63:0] p;
		p = (64'(gain) * 64'(f) + HALF_LSB) >> 16;
		return (p > 64'(GAIN_SAT)) ? GAIN_SAT : p[23:0];
	endfunction

	function automatic factors_t stage_factors(input logic [STAGE_W-1:0] stg);
		case (stg)
			STG_PREHEAT:  return '{kp: 18'd78643, ki: 18'd32768, kd: 18'd52429};
			STG_SOAK:     return '{kp: 18'd52429, ki: 18'd98304, kd: 18'd32768};
			STG_RAMP:     return '{kp: 18'd65536, ki: 18'd65536, kd: 18'd85197};
			STG_PEAK:     return '{kp: 18'd39322, ki: 18'd19661, kd: 18'd117965};
			STG_COOLDOWN: return '{kp: 18'd6554, ki: 18'd0, kd: 18'd6554};
			default:      return '{kp: UNITY, ki: UNITY, kd: UNITY};
		endcase
	endfunction

	// gains for one reading; updates the spread history when learning is on
	task automatic predict_gains(input reading_t r, output gains_t g);
		logic [23:0] kp;
		logic [23:0] ki;
		logic [23:0] kd;
		logic [63:0] q;
		logic [17:0] damp;
		factors_t    f;
		int          err;
		int          derr;
		int          aerr;
		int          aderr;
		kp = gain_kp;
		ki = gain_ki;
		kd = gain_kd;
		if (stage_tune_on && r.stage < STG_COUNT) begin
			f = stage_factors(r.stage);
			kp = scale_q16(kp, f.kp);
			ki = scale_q16(ki, f.ki);
			kd = scale_q16(kd, f.kd);
		end
		// spread damping with a floor on the kp factor
		if (int'(r.spread) > SPREAD_KNEE) begin
			q = (64'(int'(r.spread) - SPREAD_KNEE) << 16) / 64'(DAMP_SPAN);
			damp = (q >= 64'(UNITY - DAMP_FLOOR)) ? DAMP_FLOOR : 18'(64'(UNITY) - q);
			kp = scale_q16(kp, damp);
			kd = scale_q16(kd, 18'(2 * UNITY) - damp);
			damped_count++;
		end
		// integral boost compares the error against the stored spread
		if (learn_on) begin
			err = int'(r.target) * TEMP_SCALE - int'(r.avg);
			derr = err - int'(last_spread);
			aerr = (err < 0) ? -err : err;
			aderr = (derr < 0) ? -derr : derr;
			if (aderr > BOOST_GAP && aerr < ERR_WINDOW) begin
				ki = scale_q16(ki, KI_BOOST);
				boosted_count++;
			end
			last_spread = r.spread;
		end
		g = '{kd: kd, ki: ki, kp: kp};
	endtask

	// wait until every pending gain set is back, then a short pause
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_gains.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_BASE_KP:    gain_kp = data;
			REG_BASE_KI:    gain_ki = data;
			REG_BASE_KD:    gain_kd = data;
			REG_STAGE_TUNE: stage_tune_on = data[0];
			REG_LEARN:      learn_on = data[0];
			default:        ;
		endcase
		reg_writes++;
	endtask

	// one input transaction; the expectation is queued on acceptance
	task automatic send_reading(input reading_t r, input logic fixed, input gains_t want);
		gains_t g;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_W'(r);
		do @(posedge clk); while (!s_tready);
		predict_gains(r, g);
		pending_gains.push_back(fixed ? want : g);
		readings_sent++;
	endtask

	// mostly readings near the setpoint so the boost rule gets exercised
	task automatic make_reading(output reading_t r);
		int avg_i;
		int off;
		r.stage = STAGE_W'($urandom_range(0, 7));
		r.target = TARGET_W'($urandom_range(0, 511));
		if ($urandom_range(0, 3) == 0) begin
			r.avg = AVG_W'($urandom_range(0, 8191));
			r.spread = SPREAD_W'($urandom_range(0, 4095));
		end else begin
			off = $urandom_range(0, 800);
			avg_i = int'(r.target) * TEMP_SCALE + off - 400;
			if (avg_i < 0) avg_i = 0;
			if (avg_i > 8191) avg_i = 8191;
			r.avg = AVG_W'(avg_i);
			if ($urandom_range(0, 1) == 1)
				r.spread = SPREAD_W'($urandom_range(0, 400));
			else
				r.spread = SPREAD_W'($urandom_range(0, 4095));
		end
	endtask

	function automatic logic [23:0] pick_gain();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return GAIN_SAT;
			2:       return 24'($urandom);
			default: return 24'($urandom_range(4096, 262143));
		endcase
	endfunction

	function automatic plan_row_t plan_reading(input int a, input int s, input int t,
		input logic [STAGE_W-1:0] stg);
		plan_row_t row;
		row = '0;
		row.rd = '{stage: stg, target: TARGET_W'(t), spread: SPREAD_W'(s), avg: AVG_W'(a)};
		return row;
	endfunction

	function automatic plan_row_t plan_fixed(input int a, input int s, input int t,
		input logic [STAGE_W-1:0] stg, input logic [23:0] kp, input logic [23:0] ki,
		input logic [23:0] kd);
		plan_row_t row;
		row = plan_reading(a, s, t, stg);
		row.fixed = 1'b1;
		row.want = '{kd: kd, ki: ki, kp: kp};
		return row;
	endfunction

	function automatic plan_row_t plan_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		plan_row_t row;
		row = '0;
		row.is_reg = 1'b1;
		row.idx = idx;
		row.data = data;
		return row;
	endfunction

	// result checking and receiver back-pressure
	always @(posedge clk) begin : result_check
		gains_t got;
		gains_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_gains.size() == 0) begin
				report_mismatch("result with nothing pending, kp", got.kp, '0);
			end else begin
				want = pending_gains.pop_front();
				if (got.kp !== want.kp) report_mismatch("kp", got.kp, want.kp);
				if (got.ki !== want.ki) report_mismatch("ki", got.ki, want.ki);
				if (got.kd !== want.kd) report_mismatch("kd", got.kd, want.kd);
				gains_checked++;
			end
		end
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout at cycle %0d, %0d gain sets pending", cycle_count,
				pending_gains.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		plan_row_t plan[$];
		reading_t  r;
		gains_t    none;
		none = '0;
		gain_kp = BASE_KP_RST;
		gain_ki = BASE_KI_RST;
		gain_kd = BASE_KD_RST;
		stage_tune_on = 1'b0;
		learn_on = 1'b1;
		last_spread = '0;

		// defaults, spread at and around the knee and past the floor, odd stage codes
		plan.push_back(plan_fixed(0, 0, 0, STG_PREHEAT, BASE_KP_RST, BASE_KI_RST, BASE_KD_RST));
		plan.push_back(plan_fixed(8191, 0, 511, STG_CODE7, BASE_KP_RST, BASE_KI_RST,
			BASE_KD_RST));
		plan.push_back(plan_reading(0, 320, 10, STG_SOAK));
		plan.push_back(plan_reading(100, 321, 511, STG_RAMP));
		plan.push_back(plan_reading(4000, 778, 250, STG_PEAK));
		plan.push_back(plan_reading(4000, 779, 250, STG_COOLDOWN));
		plan.push_back(plan_reading(8191, 4095, 0, STG_OTHER));
		// every stage code with the table enabled
		plan.push_back(plan_reg(REG_STAGE_TUNE, 24'd1));
		plan.push_back(plan_reading(3200, 100, 200, STG_PREHEAT));
		plan.push_back(plan_reading(3250, 900, 200, STG_SOAK));
		plan.push_back(plan_reading(3100, 2000, 200, STG_RAMP));
		plan.push_back(plan_reading(3200, 330, 200, STG_PEAK));
		plan.push_back(plan_reading(1000, 0, 40, STG_COOLDOWN));
		plan.push_back(plan_reading(3200, 50, 200, STG_OTHER));
		plan.push_back(plan_reading(7000, 600, 440, STG_CODE6));
		plan.push_back(plan_reading(5, 4095, 1, STG_CODE7));
		// saturation at full-scale base gains
		plan.push_back(plan_reg(REG_BASE_KP, GAIN_SAT));
		plan.push_back(plan_reg(REG_BASE_KI, GAIN_SAT));
		plan.push_back(plan_reg(REG_BASE_KD, GAIN_SAT));
		plan.push_back(plan_reading(0, 4095, 0, STG_PEAK));
		plan.push_back(plan_reading(4800, 0, 300, STG_RAMP));
		// zero base gains give zero everywhere
		plan.push_back(plan_reg(REG_BASE_KP, 24'd0));
		plan.push_back(plan_reg(REG_BASE_KI, 24'd0));
		plan.push_back(plan_reg(REG_BASE_KD, 24'd0));
		plan.push_back(plan_fixed(1234, 4095, 77, STG_PREHEAT, '0, '0, '0));
		// learning off keeps the history; only bit 0 of the enables counts
		plan.push_back(plan_reg(REG_BASE_KP, 24'h030000));
		plan.push_back(plan_reg(REG_BASE_KI, 24'h001000));
		plan.push_back(plan_reg(REG_BASE_KD, 24'h010000));
		plan.push_back(plan_reg(REG_LEARN, 24'hFFFFFE));
		plan.push_back(plan_reading(3200, 2000, 200, STG_SOAK));
		plan.push_back(plan_reg(REG_LEARN, 24'h000001));
		plan.push_back(plan_reading(3200, 50, 200, STG_RAMP));
		plan.push_back(plan_reg(REG_STAGE_TUNE, 24'hFFFFFE));
		// writes past the register map change nothing
		plan.push_back(plan_reg(REG_SPARE_A, 24'h123456));
		plan.push_back(plan_reg(REG_SPARE_B, 24'h000000));
		plan.push_back(plan_reg(REG_SPARE_C, GAIN_SAT));
		plan.push_back(plan_reading(3300, 500, 200, STG_SOAK));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_reg)
				write_reg(plan[i].idx, plan[i].data);
			else
				send_reading(plan[i].rd, plan[i].fixed, plan[i].want);
		end

		// random readings under changing settings and idle patterns
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			if (seg < 2) begin
				send_idle_pct = 17;
				recv_idle_pct = 66;
			end else if (seg < 4) begin
				send_idle_pct = 66;
				recv_idle_pct = 17;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_reg(REG_BASE_KP, pick_gain());
			write_reg(REG_BASE_KI, pick_gain());
			write_reg(REG_BASE_KD, pick_gain());
			write_reg(REG_STAGE_TUNE, {23'($urandom), 1'((seg % 2) == 0)});
			write_reg(REG_LEARN, {23'($urandom), 1'(seg != 3)});
			for (int n = 0; n < SEG_READINGS; n++) begin
				make_reading(r);
				send_reading(r, 1'b0, none);
			end
		end

		s_tvalid <= 1'b0;
		while (pending_gains.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d readings sent, %0d gain sets checked, %0d register writes",
			readings_sent, gains_checked, reg_writes);
		$display("%0d readings damped by spread, %0d with the integral boost",
			damped_count, boosted_count);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
